@@ src/mandelbrot_orbit_tracer_assert.svh @@
// assertion macros for the mandelbrot orbit tracer
// no dependencies; included by the top level
`ifndef MANDELBROT_ORBIT_TRACER_ASSERT_SVH
`define MANDELBROT_ORBIT_TRACER_ASSERT_SVH

// same-cycle implication
`define MOT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MOT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/mot_pkg.sv @@
// package for the mandelbrot orbit tracer: widths, register codes, reset values
// and the saturation helpers used by the top level
`timescale 1ns / 1ps
package mot_pkg;

   localparam int MAX_ORBIT  = 63;
   localparam int PIXEL_BITS = 12;
   localparam int ITER_W     = 6;
   localparam int REQ_W      = ((2 * PIXEL_BITS + 7) / 8) * 8;
   localparam int RSP_W      = 40;
   localparam int MUL_W      = 33;
   localparam int PROD_W     = 2 * MUL_W;
   localparam int SUM_W      = 50;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_REAL = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_IMAG = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_REAL   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_IMAG   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_X     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_Y     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_ORBIT_LEN   = 3'd6;

   localparam logic signed [31:0] ORIGIN_REAL_RST = -32'sd644245094;
   localparam logic signed [31:0] ORIGIN_IMAG_RST = -32'sd456340275;
   localparam logic [30:0]        STEP_RST        = 31'd3042260;
   localparam logic [31:0]        SCALE_RST       = 32'd5782588;
   localparam logic [5:0]         ORBIT_LEN_RST   = 6'd32;

   typedef logic signed [MUL_W-1:0]  mul_op_type;
   typedef logic signed [PROD_W-1:0] prod_type;

   // bit 32 flags saturation, bits 31:0 hold the clamped value
   function automatic logic [32:0] sat32(input logic signed [SUM_W-1:0] v);
      logic [32:0] r;
      if (v > $signed(SUM_W'(32'h7fffffff))) begin
         r = {1'b1, 32'h7fffffff};
      end else if (v < -$signed(SUM_W'(33'h080000000))) begin
         r = {1'b1, 32'h80000000};
      end else begin
         r = {1'b0, v[31:0]};
      end
      return r;
   endfunction

   // magnitude product shifted by 44, sign applied, clamped to 16 bits
   function automatic logic [15:0] to_screen(input logic [19:0] p, input logic neg);
      logic [15:0] r;
      if (neg) begin
         r = (p > 20'd32768) ? 16'h8000 : 16'(-p[15:0]);
      end else begin
         r = (p > 20'd32767) ? 16'h7fff : p[15:0];
      end
      return r;
   endfunction

   function automatic logic [15:0] pix_to_screen(input logic [PIXEL_BITS-1:0] p);
      logic [16:0] w;
      w = 17'(p);
      return (w > 17'd32767) ? 16'h7fff : w[15:0];
   endfunction

endpackage

@@ src/mandelbrot_orbit_tracer.sv @@
// mandelbrot orbit tracer top level; depends on mot_pkg, mot_mul and the assert header
// start pixel: states CRE, CIM, PIX, then EMIT, which waits on a blocked output
// each further orbit point: XX, YY, XY, NEW, DIF, MX, MY, SY and EMIT, with five
// products on the shared multiplier (x*x, y*y, x*y, then two screen scalings) and
// update, offset and emit steps; new requests are taken only in the idle state
// reset: synchronous, active high; restores the default view and clears control state
`timescale 1ns / 1ps
`include "mandelbrot_orbit_tracer_assert.svh"
module mandelbrot_orbit_tracer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [mot_pkg::REQ_W-1:0]     req_tdata,   // pixel_x, pixel_y
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [mot_pkg::RSP_W-1:0]     rsp_tdata,   // screen_x, screen_y, step_index
   output logic                          rsp_tuser,   // overflowed
   output logic                          rsp_tlast,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [mot_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [mot_pkg::CSR_DATA_W-1:0] csr_data
);
   import mot_pkg::*;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_CRE  = 4'd1;
   localparam logic [3:0] S_CIM  = 4'd2;
   localparam logic [3:0] S_PIX  = 4'd3;
   localparam logic [3:0] S_EMIT = 4'd4;
   localparam logic [3:0] S_XX   = 4'd5;
   localparam logic [3:0] S_YY   = 4'd6;
   localparam logic [3:0] S_XY   = 4'd7;
   localparam logic [3:0] S_NEW  = 4'd8;
   localparam logic [3:0] S_DIF  = 4'd9;
   localparam logic [3:0] S_MX   = 4'd10;
   localparam logic [3:0] S_MY   = 4'd11;
   localparam logic [3:0] S_SY   = 4'd12;

   // configuration registers
   logic signed [31:0] origin_real_ff, origin_imag_ff;
   logic [30:0]        step_real_ff, step_imag_ff;
   logic [31:0]        scale_x_ff, scale_y_ff;
   logic [5:0]         orbit_len_ff;

   logic [3:0]            state_ff, state_in;
   logic [PIXEL_BITS-1:0] px_ff, px_in, py_ff, py_in;
   logic signed [31:0]    cre_ff, cre_in, cim_ff, cim_in;
   logic signed [31:0]    x_ff, x_in, y_ff, y_in;
   logic signed [63:0]    sq_ff, sq_in;
   logic signed [35:0]    re_ff, re_in;
   logic [31:0]           magx_ff, magx_in, magy_ff, magy_in;
   logic                  negx_ff, negx_in, negy_ff, negy_in;
   logic                  ov_ff, ov_in;
   logic [ITER_W-1:0]     iter_ff, iter_in;
   logic [15:0]           pend_sx_ff, pend_sx_in, pend_sy_ff, pend_sy_in;
   logic                  pend_last_ff, pend_last_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [15:0]           rsp_sx_ff, rsp_sx_in, rsp_sy_ff, rsp_sy_in;
   logic [ITER_W-1:0]     rsp_step_ff, rsp_step_in;
   logic                  rsp_ov_ff, rsp_ov_in, rsp_last_ff, rsp_last_in;

   mul_op_type op_a, op_b;
   prod_type   product;

   logic [ITER_W-1:0]  n_lim;
   logic               req_xfer, out_free;
   logic [32:0]        sat_a, sat_b;
   logic signed [63:0] diff;
   logic signed [32:0] dxp, dxn, dyp, dyn;

   mot_mul u_mul (
      .clock   (clock),
      .op_a    (op_a),
      .op_b    (op_b),
      .product (product)
   );

   assign n_lim      = (7'(orbit_len_ff) > 7'(MAX_ORBIT)) ? ITER_W'(MAX_ORBIT) : orbit_len_ff;
   assign req_tready = (state_ff == S_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign csr_ready  = 1'b1;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_step_ff, rsp_sy_ff, rsp_sx_ff};
   assign rsp_tuser  = rsp_ov_ff;
   assign rsp_tlast  = rsp_last_ff;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         origin_real_ff <= ORIGIN_REAL_RST;
         origin_imag_ff <= ORIGIN_IMAG_RST;
         step_real_ff   <= STEP_RST;
         step_imag_ff   <= STEP_RST;
         scale_x_ff     <= SCALE_RST;
         scale_y_ff     <= SCALE_RST;
         orbit_len_ff   <= ORBIT_LEN_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_ORIGIN_REAL: origin_real_ff <= csr_data;
            CSR_ORIGIN_IMAG: origin_imag_ff <= csr_data;
            CSR_STEP_REAL:   step_real_ff   <= csr_data[30:0];
            CSR_STEP_IMAG:   step_imag_ff   <= csr_data[30:0];
            CSR_SCALE_X:     scale_x_ff     <= csr_data;
            CSR_SCALE_Y:     scale_y_ff     <= csr_data;
            CSR_ORBIT_LEN:   orbit_len_ff   <= csr_data[5:0];
            default: ;
         endcase
      end
   end

   // operand select for the shared multiplier
   always_comb begin
      op_a = MUL_W'(px_ff);
      op_b = MUL_W'(step_real_ff);
      unique case (state_ff)
         S_CIM: begin
            op_a = MUL_W'(py_ff);
            op_b = MUL_W'(step_imag_ff);
         end
         S_XX: begin
            op_a = MUL_W'(x_ff);
            op_b = MUL_W'(x_ff);
         end
         S_YY: begin
            op_a = MUL_W'(y_ff);
            op_b = MUL_W'(y_ff);
         end
         S_XY: begin
            op_a = MUL_W'(x_ff);
            op_b = MUL_W'(y_ff);
         end
         S_MX: begin
            op_a = $signed({1'b0, magx_ff});
            op_b = $signed({1'b0, scale_x_ff});
         end
         S_MY: begin
            op_a = $signed({1'b0, magy_ff});
            op_b = $signed({1'b0, scale_y_ff});
         end
         default: ;
      endcase
   end

   // adders around the multiplier
   always_comb begin
      sat_a = sat32(SUM_W'(origin_real_ff) + $signed({1'b0, product[SUM_W-2:0]}));
      sat_b = sat32(SUM_W'(origin_imag_ff) + $signed({1'b0, product[SUM_W-2:0]}));
      diff  = sq_ff - product[63:0];
      dxp   = 33'(x_ff) - 33'(origin_real_ff);
      dxn   = 33'(origin_real_ff) - 33'(x_ff);
      dyp   = 33'(y_ff) - 33'(origin_imag_ff);
      dyn   = 33'(origin_imag_ff) - 33'(y_ff);
      unique case (state_ff)
         S_NEW: begin
            sat_a = sat32(SUM_W'(re_ff) + SUM_W'(cre_ff));
            sat_b = sat32(SUM_W'($signed(product[63:27])) + SUM_W'(cim_ff));
         end
         default: ;
      endcase
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      cre_in       = cre_ff;
      cim_in       = cim_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      sq_in        = sq_ff;
      re_in        = re_ff;
      magx_in      = magx_ff;
      magy_in      = magy_ff;
      negx_in      = negx_ff;
      negy_in      = negy_ff;
      ov_in        = ov_ff;
      iter_in      = iter_ff;
      pend_sx_in   = pend_sx_ff;
      pend_sy_in   = pend_sy_ff;
      pend_last_in = pend_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_sx_in    = rsp_sx_ff;
      rsp_sy_in    = rsp_sy_ff;
      rsp_step_in  = rsp_step_ff;
      rsp_ov_in    = rsp_ov_ff;
      rsp_last_in  = rsp_last_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               px_in    = req_tdata[PIXEL_BITS-1:0];
               py_in    = req_tdata[2*PIXEL_BITS-1:PIXEL_BITS];
               ov_in    = 1'b0;
               iter_in  = '0;
               state_in = S_CRE;
            end
         end
         S_CRE: state_in = S_CIM;
         S_CIM: begin
            cre_in   = sat_a[31:0];
            ov_in    = ov_ff | sat_a[32];
            state_in = S_PIX;
         end
         S_PIX: begin
            cim_in       = sat_b[31:0];
            ov_in        = ov_ff | sat_b[32];
            x_in         = cre_ff;
            y_in         = sat_b[31:0];
            pend_sx_in   = pix_to_screen(px_ff);
            pend_sy_in   = pix_to_screen(py_ff);
            pend_last_in = (n_lim == '0);
            state_in     = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_sx_in    = pend_sx_ff;
               rsp_sy_in    = pend_sy_ff;
               rsp_step_in  = iter_ff;
               rsp_ov_in    = ov_ff;
               rsp_last_in  = pend_last_ff;
               state_in     = pend_last_ff ? S_IDLE : S_XX;
            end
         end
         S_XX: begin
            iter_in  = iter_ff + 1'b1;
            state_in = S_YY;
         end
         S_YY: begin
            sq_in    = product[63:0];
            state_in = S_XY;
         end
         S_XY: begin
            re_in    = diff[63:28];
            state_in = S_NEW;
         end
         S_NEW: begin
            x_in     = sat_a[31:0];
            y_in     = sat_b[31:0];
            ov_in    = ov_ff | sat_a[32] | sat_b[32];
            state_in = S_DIF;
         end
         S_DIF: begin
            negx_in  = dxp[32];
            negy_in  = dyp[32];
            magx_in  = dxp[32] ? dxn[31:0] : dxp[31:0];
            magy_in  = dyp[32] ? dyn[31:0] : dyp[31:0];
            state_in = S_MX;
         end
         S_MX: state_in = S_MY;
         S_MY: begin
            pend_sx_in = to_screen(product[63:44], negx_ff);
            state_in   = S_SY;
         end
         S_SY: begin
            pend_sy_in   = to_screen(product[63:44], negy_ff);
            pend_last_in = (iter_ff == n_lim);
            state_in     = S_EMIT;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         iter_ff      <= '0;
         ov_ff        <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         iter_ff      <= iter_in;
         ov_ff        <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      px_ff        <= px_in;
      py_ff        <= py_in;
      cre_ff       <= cre_in;
      cim_ff       <= cim_in;
      x_ff         <= x_in;
      y_ff         <= y_in;
      sq_ff        <= sq_in;
      re_ff        <= re_in;
      magx_ff      <= magx_in;
      magy_ff      <= magy_in;
      negx_ff      <= negx_in;
      negy_ff      <= negy_in;
      pend_sx_ff   <= pend_sx_in;
      pend_sy_ff   <= pend_sy_in;
      pend_last_ff <= pend_last_in;
      rsp_sx_ff    <= rsp_sx_in;
      rsp_sy_ff    <= rsp_sy_in;
      rsp_step_ff  <= rsp_step_in;
      rsp_ov_ff    <= rsp_ov_in;
      rsp_last_ff  <= rsp_last_in;
   end

   `MOT_ASSERT_NOW(a_last_step, clock, reset, rsp_valid_ff && rsp_last_ff, rsp_step_ff == n_lim, "last transfer with wrong step index")
   `MOT_ASSERT_NOW(a_iter_bound, clock, reset, state_ff != S_IDLE, iter_ff <= n_lim, "iteration count past orbit length")
   `MOT_ASSERT_NEXT(a_emit_hold, clock, reset, state_ff == S_EMIT && rsp_valid_ff && !rsp_tready, state_ff == S_EMIT, "emit step left while output blocked")

endmodule

@@ src/mot_mul.sv @@
// shared signed multiplier with registered product
// depends on mot_pkg
`timescale 1ns / 1ps
module mot_mul (
   input  logic              clock,
   input  mot_pkg::mul_op_type op_a,
   input  mot_pkg::mul_op_type op_b,
   output mot_pkg::prod_type   product
);
   import mot_pkg::*;

   prod_type prod_ff;
   prod_type prod_in;

   assign prod_in = op_a * op_b;
   assign product = prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// testbench for mandelbrot_orbit_tracer: feeds pixel requests and view register writes,
// predicts every orbit point in fixed point and checks the response stream in order
// depends on mot_pkg and the mandelbrot_orbit_tracer rtl
module testbench;
   import mot_pkg::*;

   localparam int CYCLE_LIMIT  = 1000000;
   localparam int DRAIN_CYCLES = 20;
   localparam int HOLD_CYCLES  = 1500;
   localparam int RANDOM_VIEWS = 8;
   localparam int VIEW_PIXELS  = 21;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 3'd7;

   typedef struct packed {
      logic [PIXEL_BITS-1:0] py;
      logic [PIXEL_BITS-1:0] px;
   } pixel_type;

   typedef struct {
      logic [15:0] sx;
      logic [15:0] sy;
      logic [5:0]  idx;
      logic        ovf;
      logic        last;
   } orbit_point_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_W-1:0]      req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_W-1:0]      rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // current view, tracked from register write transfers
   logic signed [31:0] view_org_re = ORIGIN_REAL_RST;
   logic signed [31:0] view_org_im = ORIGIN_IMAG_RST;
   logic [30:0]        view_step_re = STEP_RST;
   logic [30:0]        view_step_im = STEP_RST;
   logic [31:0]        view_scale_x = SCALE_RST;
   logic [31:0]        view_scale_y = SCALE_RST;
   logic [5:0]         view_orbit_len = ORBIT_LEN_RST;

   pixel_type       pending_pixels[$];
   orbit_point_type expected_points[$];
   orbit_point_type got_point;
   orbit_point_type want_point;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_left = 0;
   int cycle_count = 0;
   int requests_accepted = 0;
   int points_checked = 0;
   int overflow_points = 0;
   int view_count = 0;
   int mismatches = 0;

   mandelbrot_orbit_tracer u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #10 clock = ~clock;

   function automatic longint clamp_q428(input longint v, inout bit ovf);
      if (v > 64'sd2147483647) begin
         ovf = 1'b1;
         return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
         ovf = 1'b1;
         return -64'sd2147483648;
      end
      return v;
   endfunction

   // (z - origin) * scale, truncated toward zero, clamped to 16 bits signed
   function automatic logic [15:0] screen_coord(input longint z, input longint org,
                                                input logic [31:0] scale);
      longint      d;
      logic [63:0] mag;
      logic [63:0] prod;
      d = z - org;
      mag = (d < 0) ? -d : d;
      prod = (mag * {32'd0, scale}) >> 44;
      if (d < 0) begin
         return (prod > 64'd32768) ? 16'h8000 : 16'(-prod);
      end
      return (prod > 64'd32767) ? 16'h7fff : prod[15:0];
   endfunction

   function automatic void predict_orbit(input pixel_type p);
      longint          cre, cim, x, y, nx, ny;
      bit              ovf;
      orbit_point_type pt;
      int              i;
      ovf = 1'b0;
      cre = clamp_q428(longint'(view_org_re) + longint'(p.px) * longint'(view_step_re), ovf);
      cim = clamp_q428(longint'(view_org_im) + longint'(p.py) * longint'(view_step_im), ovf);
      x = cre;
      y = cim;
      pt.sx = 16'(p.px);
      pt.sy = 16'(p.py);
      pt.idx = '0;
      pt.ovf = ovf;
      pt.last = (view_orbit_len == 0);
      expected_points.insert(expected_points.size(), pt);
      for (i = 1; i <= view_orbit_len; i++) begin
         nx = ((x * x - y * y) >>> 28) + cre;
         ny = ((x * y) >>> 27) + cim;
         x = clamp_q428(nx, ovf);
         y = clamp_q428(ny, ovf);
         pt.sx = screen_coord(x, view_org_re, view_scale_x);
         pt.sy = screen_coord(y, view_org_im, view_scale_y);
         pt.idx = 6'(i);
         pt.ovf = ovf;
         pt.last = (i == view_orbit_len);
         expected_points.insert(expected_points.size(), pt);
      end
   endfunction

   function automatic void push_pixel(input logic [PIXEL_BITS-1:0] px,
                                      input logic [PIXEL_BITS-1:0] py);
      pending_pixels.insert(pending_pixels.size(), {py, px});
   endfunction

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_ORIGIN_REAL: view_org_re = value;
         CSR_ORIGIN_IMAG: view_org_im = value;
         CSR_STEP_REAL:   view_step_re = value[30:0];
         CSR_STEP_IMAG:   view_step_im = value[30:0];
         CSR_SCALE_X:     view_scale_x = value;
         CSR_SCALE_Y:     view_scale_y = value;
         CSR_ORBIT_LEN:   view_orbit_len = value[5:0];
         default: ;
      endcase
   endtask

   // sampled on the falling edge so every transfer of the rising edge has settled
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_pixels.size() != 0 || req_tvalid || expected_points.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic random_view();
      logic [31:0] jitter_re;
      logic [31:0] jitter_im;
      view_count++;
      if ($urandom_range(3) != 0) begin
         // a view near the set, so orbits run long before they blow up
         jitter_re = $urandom_range(32'h0fffffff) - 32'h08000000;
         jitter_im = $urandom_range(32'h0fffffff) - 32'h08000000;
         write_csr(CSR_ORIGIN_REAL, ORIGIN_REAL_RST + jitter_re);
         write_csr(CSR_ORIGIN_IMAG, ORIGIN_IMAG_RST + jitter_im);
         write_csr(CSR_STEP_REAL, $urandom_range(400000, 20000));
         write_csr(CSR_STEP_IMAG, $urandom_range(400000, 20000));
         write_csr(CSR_SCALE_X, $urandom_range(32'h08000000, 32'h00400000));
         write_csr(CSR_SCALE_Y, $urandom_range(32'h08000000, 32'h00400000));
         write_csr(CSR_ORBIT_LEN,
                   ($urandom_range(3) == 0) ? $urandom_range(63, 17) : $urandom_range(16, 1));
      end else begin
         write_csr(CSR_ORIGIN_REAL, $urandom());
         write_csr(CSR_ORIGIN_IMAG, $urandom());
         write_csr(CSR_STEP_REAL, $urandom());
         write_csr(CSR_STEP_IMAG, $urandom());
         write_csr(CSR_SCALE_X, $urandom());
         write_csr(CSR_SCALE_Y, $urandom());
         write_csr(CSR_ORBIT_LEN, $urandom_range(63));
      end
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_orbit(req_tdata);
            requests_accepted++;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_pixels.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_tvalid <= 1'b1;
               req_tdata <= pending_pixels.pop_front();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got_point.sx = rsp_tdata[15:0];
            got_point.sy = rsp_tdata[31:16];
            got_point.idx = rsp_tdata[37:32];
            got_point.ovf = rsp_tuser;
            got_point.last = rsp_tlast;
            points_checked++;
            if (got_point.ovf) overflow_points++;
            if (expected_points.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("unexpected orbit point: x %0d y %0d step %0d ovf %b last %b",
                           $signed(got_point.sx), $signed(got_point.sy), got_point.idx,
                           got_point.ovf, got_point.last);
               end
            end else begin
               want_point = expected_points.pop_front();
               if (got_point.sx !== want_point.sx || got_point.sy !== want_point.sy ||
                   got_point.idx !== want_point.idx || got_point.ovf !== want_point.ovf ||
                   got_point.last !== want_point.last) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("orbit point mismatch at %0t: expected x %0d y %0d step %0d ovf %b last %b",
                              $time, $signed(want_point.sx), $signed(want_point.sy),
                              want_point.idx, want_point.ovf, want_point.last);
                     $display("   got x %0d y %0d step %0d ovf %b last %b",
                              $signed(got_point.sx), $signed(got_point.sy), got_point.idx,
                              got_point.ovf, got_point.last);
                  end
               end
            end
         end
         rsp_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // long receiver hold-off
   always @(posedge clock) begin
      if (hold_left > 0) hold_left <= hold_left - 1;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d orbit points still expected",
                  cycle_count, expected_points.size());
         $display("mandelbrot_orbit_tracer test failed");
         $finish;
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset view: corners, alternating bits and a point inside the set
      view_count++;
      push_pixel(12'd0, 12'd0);
      push_pixel(12'hfff, 12'hfff);
      push_pixel(12'hfff, 12'd0);
      push_pixel(12'd0, 12'hfff);
      push_pixel(12'haaa, 12'h555);
      push_pixel(12'h555, 12'haaa);
      push_pixel(12'd150, 12'd150);
      wait_idle();

      // zero orbit length gives only the start pixel; unknown index is ignored
      view_count++;
      write_csr(CSR_ORBIT_LEN, 32'd0);
      write_csr(CSR_UNUSED, 32'hdeadbeef);
      push_pixel(12'd0, 12'd0);
      push_pixel(12'hfff, 12'hfff);
      wait_idle();

      // extreme view: c saturates, screen clamps high, longest orbit
      view_count++;
      write_csr(CSR_ORIGIN_REAL, 32'h80000000);
      write_csr(CSR_ORIGIN_IMAG, 32'h80000000);
      write_csr(CSR_STEP_REAL, 32'h7fffffff);
      write_csr(CSR_STEP_IMAG, 32'h7fffffff);
      write_csr(CSR_SCALE_X, 32'hffffffff);
      write_csr(CSR_SCALE_Y, 32'hffffffff);
      write_csr(CSR_ORBIT_LEN, 32'd63);
      push_pixel(12'hfff, 12'hfff);
      push_pixel(12'd0, 12'd0);
      push_pixel(12'd1, 12'd1);
      wait_idle();

      // orbit swings below the origin so the screen clamps low; zero step, zero y scale
      view_count++;
      write_csr(CSR_ORIGIN_REAL, 32'd0);
      write_csr(CSR_ORIGIN_IMAG, 32'h7fffffff);
      write_csr(CSR_STEP_REAL, 32'd0);
      write_csr(CSR_STEP_IMAG, 32'd0);
      write_csr(CSR_SCALE_X, 32'hffffffff);
      write_csr(CSR_SCALE_Y, 32'd0);
      write_csr(CSR_ORBIT_LEN, 32'd5);
      push_pixel(12'hfff, 12'd0);
      push_pixel(12'd0, 12'hfff);
      wait_idle();

      for (int ph = 0; ph < RANDOM_VIEWS; ph++) begin
         random_view();
         send_idle_pct = (ph % 4 == 1) ? 66 : (ph % 4 == 3) ? 11 : 0;
         recv_stall_pct = (ph % 4 == 2) ? 66 : (ph % 4 == 3) ? 11 : 0;
         repeat (VIEW_PIXELS) push_pixel($urandom_range(4095), $urandom_range(4095));
         if (ph == 4) hold_left <= HOLD_CYCLES;
         wait_idle();
      end

      $display("covered %0d pixel requests over %0d views, %0d orbit points checked",
               requests_accepted, view_count, points_checked);
      $display("%0d points carried the overflow flag, %0d mismatches",
               overflow_points, mismatches);
      if (mismatches == 0) begin
         $display("mandelbrot_orbit_tracer test passed");
      end else begin
         $display("mandelbrot_orbit_tracer test failed");
      end
      $finish;
   end

endmodule
